// ===== rtl/ant_pkg.sv =====
// Shared types and constants for the aging node table.
`default_nettype none
package ant_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic [CFG_AW-3:0] reg_idx_t;
  localparam reg_idx_t REG_TIMEOUT = '0;
  localparam logic [31:0] TIMEOUT_RESET = 32'd3600;

  typedef logic [1:0]  kind_t;
  typedef logic [63:0] serial_t;
  typedef logic [15:0] address_t;
  typedef logic [31:0] stamp_t;

  localparam kind_t KIND_UPDATE = 2'd0;
  localparam kind_t KIND_PURGE  = 2'd1;
  localparam kind_t KIND_LOOKUP = 2'd2;

  typedef struct packed {
    serial_t  serial;
    address_t address;
    stamp_t   stamp;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/ant_if.sv =====
// Request and result channel interfaces of the aging node table.
`default_nettype none
interface ant_in_if;
  import ant_pkg::*;
  logic     valid;
  logic     ready;
  kind_t    kind;
  serial_t  node_serial;
  address_t node_address;
  stamp_t   now;

  modport source (output valid, kind, node_serial, node_address, now, input ready);
  modport sink   (input valid, kind, node_serial, node_address, now, output ready);
endinterface

interface ant_out_if;
  import ant_pkg::*;
  logic     valid;
  logic     ready;
  logic     found;
  address_t found_address;

  modport source (output valid, found, found_address, input ready);
  modport sink   (input valid, found, found_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/ant_cfg.sv =====
// APB-style register port holding the purge timeout.
`default_nettype none
module ant_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ant_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ant_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ant_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output ant_pkg::stamp_t              timeout
);
  import ant_pkg::*;

  stamp_t   timeout_r;
  reg_idx_t widx;
  logic     wr_hit;

  assign widx       = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (widx == REG_TIMEOUT);
  assign cfg_prdata = (widx == REG_TIMEOUT) ? timeout_r : '0;
  assign timeout    = timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (wr_hit) begin
      timeout_r <= cfg_pwdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ant_mem.sv =====
// Node table memory: one write port, one registered read port.
`default_nettype none
module ant_mem #(
  parameter int TABLE_DEPTH = 16,
  parameter int IW          = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_idx,
  input  ant_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_idx,
  output ant_pkg::entry_t rd_data
);
  import ant_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ant_engine.sv =====
// Sequencer: clears the table, scans it per operation and writes back.
`default_nettype none
module ant_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int IW          = 4,
  parameter int CW          = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ant_pkg::stamp_t timeout,
  ant_in_if.sink          in_ch,
  ant_out_if.source       out_ch,
  output logic            rd_en,
  output logic [IW-1:0]   rd_idx,
  input  ant_pkg::entry_t rd_data,
  output logic            wr_en,
  output logic [IW-1:0]   wr_idx,
  output ant_pkg::entry_t wr_data
);
  import ant_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

  state_t   state_r;
  logic [CW-1:0] cnt_r;
  logic     rv_r;
  logic [IW-1:0] ridx_r;
  kind_t    kind_r;
  serial_t  serial_r;
  address_t addr_r;
  stamp_t   now_r;
  logic     hit_r;
  logic [IW-1:0] hit_idx_r;
  address_t hit_addr_r;
  logic     emp_r;
  logic [IW-1:0] emp_idx_r;
  logic     old_v_r;
  logic [IW-1:0] old_idx_r;
  stamp_t   old_age_r;
  logic     out_valid_r;
  logic     found_r;
  address_t faddr_r;

  stamp_t   age;
  logic     match;
  logic     used;
  logic     scan_end;
  logic [IW-1:0] victim;

  assign age      = now_r - rd_data.stamp;
  assign used     = rd_data.serial != '0;
  assign match    = rv_r && (serial_r != '0) && (rd_data.serial == serial_r);
  assign scan_end = (cnt_r == CW'(TABLE_DEPTH)) && !rv_r;
  assign victim   = hit_r ? hit_idx_r : (emp_r ? emp_idx_r : old_idx_r);

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.found_address = faddr_r;

  always_comb begin
    rd_en   = (state_r == S_SCAN) && (cnt_r < CW'(TABLE_DEPTH));
    rd_idx  = cnt_r[IW-1:0];
    wr_en   = 1'b0;
    wr_idx  = cnt_r[IW-1:0];
    wr_data = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        wr_idx = ridx_r;
        wr_en  = rv_r && (kind_r == KIND_PURGE) && used && (age > timeout);
      end
      S_WRITE: begin
        wr_idx  = victim;
        wr_en   = serial_r != '0;
        wr_data = '{serial: serial_r, address: addr_r, stamp: now_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      hit_r       <= 1'b0;
      emp_r       <= 1'b0;
      old_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      rv_r   <= rd_en;
      ridx_r <= rd_idx;
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(TABLE_DEPTH - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r   <= in_ch.kind;
            serial_r <= in_ch.node_serial;
            addr_r   <= in_ch.node_address;
            now_r    <= in_ch.now;
            cnt_r    <= '0;
            hit_r    <= 1'b0;
            emp_r    <= 1'b0;
            old_v_r  <= 1'b0;
            if (in_ch.kind inside {KIND_UPDATE, KIND_PURGE, KIND_LOOKUP}) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (rv_r) begin
            if (match && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= ridx_r;
              hit_addr_r <= rd_data.address;
            end
            if (!used && !emp_r) begin
              emp_r     <= 1'b1;
              emp_idx_r <= ridx_r;
            end
            if (!old_v_r || (age > old_age_r)) begin
              old_v_r   <= 1'b1;
              old_idx_r <= ridx_r;
              old_age_r <= age;
            end
          end
          if (scan_end) begin
            state_r <= (kind_r == KIND_UPDATE) ? S_WRITE : S_DONE;
          end
        end
        S_WRITE: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            found_r     <= (kind_r == KIND_LOOKUP) && hit_r;
            faddr_r     <= ((kind_r == KIND_LOOKUP) && hit_r) ? hit_addr_r : '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aging_node_table.sv =====
// Flow: each request scans every entry in S_SCAN, then S_DONE loads the result;
// update adds S_WRITE for its write-back; the unused kind goes straight to S_DONE.
// One request at a time: a new word is accepted the cycle after the result is loaded,
// and a result still held in the output register stalls S_DONE until it is taken.
// Reset: a sweep over every entry clears the table, input ready low; timeout 3600 s.
`default_nettype none
module aging_node_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ant_in_if.sink                     in_ch,
  ant_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ant_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ant_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ant_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ant_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  stamp_t        timeout;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  entry_t        wr_data;

  ant_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .timeout    (timeout)
  );

  ant_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IW         (IW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_data(rd_data)
  );

  ant_engine #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IW         (IW),
    .CW         (CW)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .timeout(timeout),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data)
  );

endmodule
`default_nettype wire

// ===== tb/aging_node_table_tb.sv =====
// Self-checking testbench for aging_node_table: directed and random traffic against a table predictor.
`default_nettype none
module aging_node_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ant_pkg::*;

  localparam int DEPTH = 16;
  localparam int POOL = 24;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  localparam serial_t SERIAL_MAX = '1;

  typedef struct packed {
    logic     found;
    address_t address;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  ant_in_if  in_ch ();
  ant_out_if out_ch ();

  aging_node_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_t  node_serials [DEPTH];
  address_t node_addrs [DEPTH];
  stamp_t   node_stamps [DEPTH];
  stamp_t   purge_timeout;
  reply_t   pending_replies [$];
  serial_t  serial_pool [POOL];
  stamp_t   mesh_clock;
  bit       no_idle;
  int unsigned recv_hold;
  int unsigned errors;

  function automatic reply_t apply_to_table(kind_t k, serial_t s, address_t a, stamp_t t);
    reply_t r;
    int slot;
    stamp_t age, oldest;
    r = '0;
    case (k)
      KIND_UPDATE: begin
        if (s != '0) begin
          slot = -1;
          for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && node_serials[i] == s) slot = i;
          for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && node_serials[i] == '0) slot = i;
          if (slot < 0) begin
            slot = 0;
            oldest = t - node_stamps[0];
            for (int i = 1; i < DEPTH; i++) begin
              age = t - node_stamps[i];
              if (age > oldest) begin
                oldest = age;
                slot = i;
              end
            end
          end
          node_serials[slot] = s;
          node_addrs[slot] = a;
          node_stamps[slot] = t;
        end
      end
      KIND_PURGE: begin
        for (int i = 0; i < DEPTH; i++) begin
          age = t - node_stamps[i];
          if (node_serials[i] != '0 && age > purge_timeout) begin
            node_serials[i] = '0;
            node_addrs[i] = '0;
            node_stamps[i] = '0;
          end
        end
      end
      KIND_LOOKUP: begin
        if (s != '0)
          for (int i = DEPTH - 1; i >= 0; i--)
            if (node_serials[i] == s) r = '{1'b1, node_addrs[i]};
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(kind_t k, serial_t s, address_t a, stamp_t t);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.node_serial <= s;
    in_ch.node_address <= a;
    in_ch.now <= t;
    do @(posedge clk); while (!in_ch.ready);
    pending_replies.push_back(apply_to_table(k, s, a, t));
  endtask

  task automatic check_reply(logic f, address_t a);
    reply_t want;
    if (pending_replies.size() == 0) begin
      $error("unexpected result word: found %0d found_address %h", f, a);
      errors++;
    end else begin
      want = pending_replies.pop_front();
      if (f !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, f);
        errors++;
      end
      if (a !== want.address) begin
        $error("found_address: expected %h, got %h", want.address, a);
        errors++;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0 || recv_hold != 0) out_ch.ready <= 1'b0;
      while (gap != 0 || recv_hold != 0) begin
        @(posedge clk);
        if (gap != 0) gap--;
        else recv_hold--;
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_reply(out_ch.found, out_ch.found_address);
    end
  end

  task automatic wait_for_replies();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= TIMEOUT_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_timeout_reg(logic [31:0] want);
    logic [CFG_DW-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== want) begin
      $error("timeout_seconds: expected %h, got %h", want, rd);
      errors++;
    end
  endtask

  task automatic set_timeout(logic [31:0] v);
    logic [CFG_DW-1:0] rd;
    wait_for_replies();
    apb_access(1'b1, v, rd);
    purge_timeout = v;
    check_timeout_reg(v);
  endtask

  task automatic random_word(int unsigned step_max);
    int unsigned pick;
    kind_t k;
    serial_t s;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) != 0) mesh_clock += $urandom_range(1, step_max);
    if (pick < 3) mesh_clock = $urandom();
    s = serial_pool[$urandom_range(0, POOL - 1)];
    if (pick < 48) k = KIND_UPDATE;
    else if (pick < 78) k = KIND_LOOKUP;
    else if (pick < 88) k = KIND_PURGE;
    else if (pick < 93) begin
      k = pick[0] ? KIND_UPDATE : KIND_LOOKUP;
      s = {$urandom(), $urandom()};
    end else if (pick < 96) begin
      k = pick[0] ? KIND_UPDATE : KIND_LOOKUP;
      s = '0;
    end else k = KIND_UNUSED;
    send_word(k, s, address_t'($urandom()), mesh_clock);
  endtask

  task automatic test_reset_state();
    check_timeout_reg(TIMEOUT_RESET);
    send_word(KIND_LOOKUP, serial_pool[3], 16'h5a5a, 32'd0);
    send_word(KIND_PURGE, '0, '0, 32'hffff_ffff);
  endtask

  task automatic test_directed_ops();
    send_word(KIND_UPDATE, SERIAL_MAX, 16'hffff, 32'hffff_ffff);
    send_word(KIND_UPDATE, 64'd1, 16'h0000, 32'd0);
    send_word(KIND_LOOKUP, SERIAL_MAX, '0, '0);
    send_word(KIND_LOOKUP, 64'd1, '0, '0);
    send_word(KIND_UPDATE, SERIAL_MAX, 16'h1234, 32'd5);
    send_word(KIND_LOOKUP, SERIAL_MAX, '0, '0);
    send_word(KIND_UPDATE, '0, 16'habcd, 32'd7);
    send_word(KIND_LOOKUP, '0, '0, '0);
    send_word(KIND_UNUSED, SERIAL_MAX, 16'hffff, 32'hffff_ffff);
    send_word(KIND_PURGE, '0, '0, 32'd3600);
    send_word(KIND_LOOKUP, 64'd1, '0, '0);
    send_word(KIND_PURGE, '0, '0, 32'd3601);
    send_word(KIND_LOOKUP, 64'd1, '0, '0);
    send_word(KIND_UPDATE, 64'd2, 16'h8001, 32'hffff_fff0);
    send_word(KIND_PURGE, '0, '0, 32'h0000_0010);
    send_word(KIND_LOOKUP, 64'd2, '0, '0);
    for (int i = 0; i < 8; i++)
      send_word(KIND_UPDATE, serial_pool[i], address_t'($urandom()), 32'd100);
    send_word(KIND_LOOKUP, serial_pool[0], '0, '0);
  endtask

  task automatic test_backpressure();
    wait_for_replies();
    no_idle = 1'b1;
    recv_hold = 150;
    for (int i = 0; i < 12; i++) random_word(50);
    no_idle = 1'b0;
    wait_for_replies();
  endtask

  task automatic test_timeout_phases();
    logic [31:0] timeouts [6];
    int unsigned steps [6];
    timeouts = '{32'd0, 32'hffff_ffff, 32'd1, 32'd40, $urandom_range(100, 2000), TIMEOUT_RESET};
    steps = '{4, 100000, 2, 20, 500, 900};
    for (int p = 0; p < 6; p++) begin
      set_timeout(timeouts[p]);
      no_idle = (p == 2 || p == 4);
      for (int i = 0; i < 250; i++) random_word(steps[p]);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_UPDATE;
    in_ch.node_serial <= '0;
    in_ch.node_address <= '0;
    in_ch.now <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    errors = 0;
    no_idle = 1'b0;
    recv_hold = 0;
    mesh_clock = 32'd1000;
    purge_timeout = TIMEOUT_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      node_serials[i] = '0;
      node_addrs[i] = '0;
      node_stamps[i] = '0;
    end
    serial_pool[0] = SERIAL_MAX;
    serial_pool[1] = 64'd1;
    serial_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < POOL; i++)
      do serial_pool[i] = {$urandom(), $urandom()}; while (serial_pool[i] == '0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_ops();
    test_backpressure();
    test_timeout_phases();

    wait_for_replies();
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0) $display("aging_node_table_tb: done, clean");
    else $display("aging_node_table_tb: done, errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("aging_node_table_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== aging_node_table.f =====
rtl/ant_pkg.sv
rtl/ant_if.sv
rtl/ant_cfg.sv
rtl/ant_mem.sv
rtl/ant_engine.sv
rtl/aging_node_table.sv
tb/aging_node_table_tb.sv
